FILE: hw/rtl/cpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and constants for the command packet deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

    // Header position of the frame parser
    typedef enum logic [1:0] {
        ST_CMD     = 2'd0,
        ST_LEN_LO  = 2'd1,
        ST_LEN_HI  = 2'd2,
        ST_PAYLOAD = 2'd3
    } t_stage;

    // Configuration register map (select values of address bit 2)
    localparam int          CFG_ADDR_W   = 3;
    localparam logic        REG_GAP      = 1'b0;
    localparam logic        REG_MAXLEN   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [15:0] GAP_RESET    = 16'd10;
    localparam logic [15:0] MAXLEN_RESET = 16'd4096;

    // Stream widths
    localparam int          IN_DATA_W    = 40;
    localparam int          OUT_DATA_W   = 48;

    // One result produced by the parser for one item
    typedef struct packed {
        logic        emit;
        logic [7:0]  cmd;
        logic [7:0]  pbyte;
        logic [15:0] poff;
        logic        pvalid;
        logic        done;
        logic [15:0] length;
    } t_result;

endpackage

FILE: hw/rtl/cpd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_parser
// Frame state and next-state logic: header decode, gap timeout, payload count.
// State advances by one step on each accepted item.
// ----------------------------------------------------------------------------
module cpd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_start,
    input  logic [31:0]       i_now,
    input  logic [15:0]       i_gap_timeout,
    input  logic [15:0]       i_max_length,
    output cpd_pkg::t_result  o_result
);
    import cpd_pkg::*;

    t_stage      r_stage, n_stage;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_len, n_len;
    logic [15:0] r_cnt, n_cnt;
    logic [31:0] r_last, n_last;

    logic [31:0] gap;
    logic        timeout;
    t_stage      stage_eff;
    logic [15:0] full_len;
    logic        over;
    logic [15:0] cnt_inc;

    // Gap check on the first byte of a transaction
    assign gap       = i_now - r_last;
    assign timeout   = i_start && (gap > {16'd0, i_gap_timeout});
    assign stage_eff = timeout ? ST_CMD : r_stage;
    assign full_len  = {i_byte, r_len[7:0]};
    assign over      = full_len > i_max_length;
    assign cnt_inc   = r_cnt + 16'd1;

    // Next state and result
    always_comb begin
        n_stage  = stage_eff;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_last   = (i_start || stage_eff == ST_CMD) ? i_now : r_last;
        o_result = '0;

        unique case (stage_eff)
            ST_CMD: begin
                n_cmd   = i_byte;
                n_len   = '0;
                n_cnt   = '0;
                n_stage = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                n_len   = {8'd0, i_byte};
                n_stage = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                n_len   = over ? 16'd0 : full_len;
                n_stage = ST_PAYLOAD;
                if (over) begin
                    n_stage = ST_CMD;
                end
                if (r_cnt == n_len) begin
                    o_result.done = 1'b1;
                    n_stage       = ST_CMD;
                end
            end
            ST_PAYLOAD: begin
                if (r_cnt < r_len) begin
                    o_result.pvalid = 1'b1;
                    o_result.pbyte  = i_byte;
                    o_result.poff   = r_cnt;
                    n_cnt           = cnt_inc;
                end
                if (n_cnt >= r_len) begin
                    o_result.done = 1'b1;
                    n_stage       = ST_CMD;
                end
            end
            default: begin
                n_stage = ST_CMD;
            end
        endcase

        o_result.emit   = o_result.pvalid || o_result.done;
        o_result.cmd    = n_cmd;
        o_result.length = n_len;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_CMD;
            r_cmd   <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_last  <= '0;
        end else if (i_step) begin
            r_stage <= n_stage;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
        end
    end

endmodule

FILE: hw/rtl/command_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_packet_deframer
// Splits a byte stream into frames of command, 16-bit length and payload.
//
// Input stream: one byte per item with its millisecond timestamp; tuser flags
// the first byte of a bus write. A byte that starts a write more than
// gap_timeout_ms after the last one restarts the header.
// Output stream: one item per payload byte, plus one for a zero-length or
// over-limit frame; tlast marks the frame's last item, tuser a payload byte.
// Header bytes produce no other output item.
// o_m_tvalid is registered after input acceptance. An item can be accepted
// every cycle unless the receiver stalls; the single output register sets
// that rate. On a stall, the held item blocks input only while it waits.
// Reset (synchronous) empties the output register, returns the parser to the
// command byte and loads gap_timeout_ms = 10 and max_length = 4096.
// Registers over APB: 0x0 gap_timeout_ms, 0x4 max_length (16 bits each).
// ----------------------------------------------------------------------------
module command_packet_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [cpd_pkg::IN_DATA_W-1:0]   i_s_tdata,  // data_byte, now_ms
    input  logic                            i_s_tuser,  // start_of_write
    // Output stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // packet_cmd, payload_byte, payload_offset, packet_length
    output logic [cpd_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tuser,  // payload_valid
    output logic                            o_m_tlast,  // packet_done
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cpd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import cpd_pkg::*;

    logic [15:0] r_gap_timeout;
    logic [15:0] r_max_length;
    logic        cfg_wr;

    logic        accept;
    t_result     result;

    logic        r_out_valid;
    logic [7:0]  r_cmd;
    logic [7:0]  r_pbyte;
    logic [15:0] r_poff;
    logic        r_pvalid;
    logic        r_done;
    logic [15:0] r_length;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_timeout <= GAP_RESET;
            r_max_length  <= MAXLEN_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_GAP:    r_gap_timeout <= pwdata[15:0];
                REG_MAXLEN: r_max_length  <= pwdata[15:0];
                default:    r_gap_timeout <= r_gap_timeout;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GAP:    prdata = {16'd0, r_gap_timeout};
            REG_MAXLEN: prdata = {16'd0, r_max_length};
            default:    prdata = '0;
        endcase
    end

    // Input handshake: take an item whenever the output slot is free or drains
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    cpd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (accept),
        .i_byte        (i_s_tdata[7:0]),
        .i_start       (i_s_tuser),
        .i_now         (i_s_tdata[39:8]),
        .i_gap_timeout (r_gap_timeout),
        .i_max_length  (r_max_length),
        .o_result      (result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= accept && result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && result.emit) begin
            r_cmd    <= result.cmd;
            r_pbyte  <= result.pbyte;
            r_poff   <= result.poff;
            r_pvalid <= result.pvalid;
            r_done   <= result.done;
            r_length <= result.length;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_length, r_poff, r_pbyte, r_cmd};
    assign o_m_tuser  = r_pvalid;
    assign o_m_tlast  = r_done;

`ifndef SYNTHESIS
    // A result without a payload byte always closes a frame
    a_empty_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> o_m_tlast)
        else $error("result with neither payload nor done");

    // A result without a payload byte carries zero byte and offset
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[31:8] == 24'd0))
        else $error("non-payload result carries byte or offset");

    // Payload offset stays inside the declared length
    a_offset_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[31:16] < o_m_tdata[47:32]))
        else $error("payload offset beyond frame length");

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
`endif

endmodule
